// ----- src/rccf_pkg.sv -----
// ----------------------------------------------------------------------------
// rccf_pkg
// Shared constants and types for the rc channel conditioner with failsafe
// detection: band thresholds, scaling limits, register indexes and resets.
// ----------------------------------------------------------------------------
package rccf_pkg;

  // stored channel count default
  localparam int STORED_CHANNELS_DEF = 10;

  // item field widths
  localparam int CH_W  = 4;
  localparam int VAL_W = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINK_TIMEOUT  = 2'd0,
    REG_FAILSAFE_HOLD = 2'd1,
    REG_FAILSAFE_A    = 2'd2,
    REG_FAILSAFE_B    = 2'd3
  } cfg_reg_t;

  // operation codes
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  // register reset values
  localparam logic [VAL_W-1:0] LINK_TIMEOUT_RST  = 16'd500;
  localparam logic [VAL_W-1:0] FAILSAFE_HOLD_RST = 16'd15000;
  localparam logic [VAL_W-1:0] FAILSAFE_A_RST    = 16'd1878;
  localparam logic [VAL_W-1:0] FAILSAFE_B_RST    = 16'd1882;

  // analogue channel bands
  localparam int COND_CHANNELS = 6;
  localparam logic [VAL_W-1:0] BAND_HI_THRESH  = 16'd53000;
  localparam logic [VAL_W-1:0] BAND_HI_MIN     = 16'd54236;
  localparam logic [VAL_W-1:0] BAND_MID_THRESH = 16'd30000;
  localparam logic [VAL_W-1:0] BAND_MID_MIN    = 16'd50140;
  localparam logic [VAL_W-1:0] BAND_LO_THRESH  = 16'd800;
  localparam logic [VAL_W-1:0] BAND_LO_MIN     = 16'd21468;
  localparam int               SPAN_W          = 11;
  localparam logic [VAL_W-1:0] BAND_SPAN       = 16'd1024;
  localparam int               SCALE_SHIFT     = 10;
  localparam logic [9:0]       SCALE_MUL       = 10'd1000;

  // aux channel window and output range
  localparam logic [VAL_W-1:0] AUX_MIN = 16'd800;
  localparam logic [VAL_W-1:0] AUX_MAX = 16'd2200;
  localparam logic [VAL_W-1:0] OUT_MIN = 16'd1000;
  localparam logic [VAL_W-1:0] OUT_MAX = 16'd2000;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

endpackage

// ----- src/rccf_in_if.sv -----
// ----------------------------------------------------------------------------
// rccf_in_if
// Input item channel: one channel sample or one millisecond tick.
// ----------------------------------------------------------------------------
interface rccf_in_if;
  import rccf_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [CH_W-1:0]  channel_index;
  logic [VAL_W-1:0] raw_value;

  modport source (output valid, output opcode, output channel_index,
                  output raw_value, input ready);
  modport sink   (input valid, input opcode, input channel_index,
                  input raw_value, output ready);
endinterface

// ----- src/rccf_out_if.sv -----
// ----------------------------------------------------------------------------
// rccf_out_if
// Result channel: conditioned channel value and link status flags.
// ----------------------------------------------------------------------------
interface rccf_out_if;
  import rccf_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_channel;
  logic [VAL_W-1:0] channel_value;
  logic             rc_connected;
  logic             failsafe_confirmed;

  modport source (output valid, output out_channel, output channel_value,
                  output rc_connected, output failsafe_confirmed, input ready);
  modport sink   (input valid, input out_channel, input channel_value,
                  input rc_connected, input failsafe_confirmed, output ready);
endinterface

// ----- src/rccf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rccf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rccf_cfg_if;
  import rccf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/rccf_condition.sv -----
// ----------------------------------------------------------------------------
// rccf_condition
// Analogue channel conditioning: picks a band from the raw value, clamps into
// the 1024-wide band, scales the offset to 1000..2000; raw <= 800 passes as is.
// ----------------------------------------------------------------------------
module rccf_condition (
  input  logic [rccf_pkg::VAL_W-1:0] raw,
  output logic [rccf_pkg::VAL_W-1:0] value
);
  import rccf_pkg::*;

  logic [VAL_W-1:0]        band_lo;
  logic                    in_band;
  logic [VAL_W-1:0]        diff;
  logic [SPAN_W-1:0]       offset;
  logic [SPAN_W+9:0]       prod;
  logic [VAL_W-1:0]        scaled;

  // band selection
  always_comb begin
    in_band = 1'b1;
    if (raw > BAND_HI_THRESH) begin
      band_lo = BAND_HI_MIN;
    end else if (raw > BAND_MID_THRESH) begin
      band_lo = BAND_MID_MIN;
    end else if (raw > BAND_LO_THRESH) begin
      band_lo = BAND_LO_MIN;
    end else begin
      band_lo = BAND_LO_MIN;
      in_band = 1'b0;
    end
  end

  // clamp into the band
  always_comb begin
    diff = raw - band_lo;
    if (raw < band_lo) begin
      offset = '0;
    end else if (diff > BAND_SPAN) begin
      offset = BAND_SPAN[SPAN_W-1:0];
    end else begin
      offset = diff[SPAN_W-1:0];
    end
  end

  // scale by 1000/1024
  always_comb begin
    prod   = {10'd0, offset} * {{SPAN_W{1'b0}}, SCALE_MUL};
    scaled = OUT_MIN + {{(VAL_W-SPAN_W){1'b0}}, prod[SPAN_W+9:SCALE_SHIFT]};
    if (!in_band) begin
      value = raw;
    end else if (scaled > OUT_MAX) begin
      value = OUT_MAX;
    end else begin
      value = scaled;
    end
  end

endmodule

// ----- src/rc_channel_conditioner_failsafe.sv -----
// ----------------------------------------------------------------------------
// rc_channel_conditioner_failsafe
// Radio-control channel conditioner with link-age and failsafe detection.
// Stores conditioned channel values and reports link status per item.
//
//   channel  | dir | contents
//   ---------+-----+--------------------------------------------------------
//   sample   | in  | opcode, channel_index, raw_value (sample or ms tick)
//   result   | out | out_channel, channel_value, rc_connected, failsafe_conf.
//   cfg      | in  | index, data (four 16-bit registers, always ready)
//
// One item per cycle sustained while result is not stalled.
// An item sits in the input register, then conditioning and counter
// update write the channel store, counters and result register.
// A stalled result holds the result register; the input register still
// takes one more item, then sample.ready drops until result moves.
// Synchronous reset clears store, counters and registers to defaults.
// ----------------------------------------------------------------------------
module rc_channel_conditioner_failsafe #(
  parameter int STORED_CHANNELS = rccf_pkg::STORED_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rccf_in_if.sink     sample,
  rccf_out_if.source  result,
  rccf_cfg_if.sink    cfg
);
  import rccf_pkg::*;

  // configuration registers
  logic [VAL_W-1:0] link_timeout_ms;
  logic [VAL_W-1:0] hold_limit;
  logic [VAL_W-1:0] failsafe_value_a;
  logic [VAL_W-1:0] failsafe_value_b;

  // input register
  logic             s1_valid;
  logic             s1_opcode;
  logic [CH_W-1:0]  s1_channel;
  logic [VAL_W-1:0] s1_raw;

  // state
  logic [VAL_W-1:0] channel_store      [STORED_CHANNELS];
  logic [VAL_W-1:0] channel_store_next [STORED_CHANNELS];
  logic [VAL_W-1:0] link_age;
  logic [VAL_W-1:0] link_age_next;
  logic [VAL_W-1:0] failsafe_hold_count;
  logic [VAL_W-1:0] failsafe_hold_count_next;

  logic             advance;
  logic             result_free;
  logic             is_sample;
  logic             store_write;
  logic [VAL_W-1:0] cond_value;
  logic [VAL_W-1:0] new_value;
  logic [VAL_W-1:0] out_value;
  logic             pattern;
  logic             confirmed;

  // handshakes
  assign result_free  = !result.valid || result.ready;
  assign advance      = s1_valid && result_free;
  assign sample.ready = !s1_valid || advance;
  assign cfg.ready    = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      link_timeout_ms  <= LINK_TIMEOUT_RST;
      hold_limit       <= FAILSAFE_HOLD_RST;
      failsafe_value_a <= FAILSAFE_A_RST;
      failsafe_value_b <= FAILSAFE_B_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LINK_TIMEOUT:  link_timeout_ms  <= cfg.data;
        REG_FAILSAFE_HOLD: hold_limit       <= cfg.data;
        REG_FAILSAFE_A:    failsafe_value_a <= cfg.data;
        REG_FAILSAFE_B:    failsafe_value_b <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_opcode  <= sample.opcode;
      s1_channel <= sample.channel_index;
      s1_raw     <= sample.raw_value;
    end
  end

  // analogue conditioning
  rccf_condition u_condition (
    .raw   (s1_raw),
    .value (cond_value)
  );

  // new channel value and whether it is stored
  always_comb begin
    is_sample = (s1_opcode == OP_SAMPLE);
    if ({1'b0, s1_channel} < 5'(COND_CHANNELS)) begin
      new_value   = cond_value;
      store_write = is_sample;
    end else begin
      new_value   = s1_raw;
      store_write = is_sample && (s1_raw >= AUX_MIN) && (s1_raw <= AUX_MAX);
    end
  end

  // store update and read-back
  always_comb begin
    out_value = '0;
    for (int i = 0; i < STORED_CHANNELS; i++) begin
      if (store_write && (s1_channel == CH_W'(i))) begin
        channel_store_next[i] = new_value;
      end else begin
        channel_store_next[i] = channel_store[i];
      end
      if (is_sample && (s1_channel == CH_W'(i))) begin
        out_value = channel_store_next[i];
      end
    end
  end

  // link age and failsafe hold counters
  always_comb begin
    pattern = (channel_store_next[4] == failsafe_value_a) &&
              (channel_store_next[5] == failsafe_value_b);
    if (is_sample) begin
      link_age_next = '0;
      failsafe_hold_count_next = pattern ? failsafe_hold_count : '0;
    end else begin
      link_age_next = (link_age == VAL_MAX) ? link_age : link_age + 1'b1;
      if (!pattern) begin
        failsafe_hold_count_next = '0;
      end else if (failsafe_hold_count == VAL_MAX) begin
        failsafe_hold_count_next = failsafe_hold_count;
      end else begin
        failsafe_hold_count_next = failsafe_hold_count + 1'b1;
      end
    end
    confirmed = pattern && (failsafe_hold_count_next >= hold_limit);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORED_CHANNELS; i++) begin
        channel_store[i] <= '0;
      end
      link_age            <= VAL_MAX;
      failsafe_hold_count <= '0;
    end else if (advance) begin
      for (int i = 0; i < STORED_CHANNELS; i++) begin
        channel_store[i] <= channel_store_next[i];
      end
      link_age            <= link_age_next;
      failsafe_hold_count <= failsafe_hold_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (result_free) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.out_channel        <= is_sample ? s1_channel : '0;
      result.channel_value      <= out_value;
      result.rc_connected       <= (link_age_next < link_timeout_ms) && !confirmed;
      result.failsafe_confirmed <= confirmed;
    end
  end

endmodule
